// ===== rtl/bna_pkg.sv =====
// Shared types and constants for the block number allocator.
// No dependencies; used by the allocator, its cell and chain, and the sim files.
`timescale 1ns / 1ps
`default_nettype none

package bna_pkg;

	localparam int unsigned LIST_DEPTH = 256;
	localparam logic [31:0] FREE_MARKER = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		ACT_ALLOC   = 2'd0,
		ACT_RELEASE = 2'd1,
		ACT_INIT    = 2'd2,
		ACT_NOP     = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_EMPTY    = 2'd1,
		STATUS_RESERVED = 2'd2,
		STATUS_FULL     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CFG_RESERVED_LAST      = 2'd0,
		CFG_START_FREE_COUNT   = 2'd1,
		CFG_START_HIGHEST_USED = 2'd2,
		CFG_UNUSED             = 2'd3
	} cfg_index_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	// Scan token that walks the cell chain one slot per cycle.
	typedef struct packed {
		logic        active;
		action_t     op;
		logic        stopped;    // scan reached its target slot
		logic        hit;        // slot found (alloc: entry taken, release: entry stored)
		logic        clear_next; // release into terminator: zero the following slot
		logic [31:0] data;       // alloc: granted block, release: block to store
	} tok_t;

endpackage

`default_nettype wire

// ===== rtl/bna_if.sv =====
// Valid/ready channel interfaces for requests and responses.
// Depends on nothing; instantiated by whoever connects the allocator.
`timescale 1ns / 1ps
`default_nettype none

interface bna_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [31:0] block_number;

	modport source (output valid, action, block_number, input ready);
	modport sink   (input valid, action, block_number, output ready);
endinterface

interface bna_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] granted_block;
	logic [1:0]  status;
	logic [31:0] free_count;
	logic [31:0] highest_used;

	modport source (output valid, granted_block, status, free_count, highest_used,
		input ready);
	modport sink   (input valid, granted_block, status, free_count, highest_used,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/block_number_allocator.sv =====
// Top level of the block number allocator: control, counters, result register.
// Depends on bna_pkg, bna_if and bna_chain.
//
//   channel  dir  payload                                         transaction when
//   req      in   action, block_number                            valid && ready
//   rsp      out  granted_block, status, free_count, highest_used valid && ready
//   cfg      in   cfg_index, cfg_data                             cfg_we
//
// Allocate, release of a non-top block and init send a token through all 256
// cells of the free list chain, one cell per cycle; the result waits in ST_DONE
// until the output register is free, and the next request is taken back in idle.
// Empty allocate, reserved release, release of the highest block and the unused
// action answer from idle without a scan. One request is in flight at a time.
// Reset leaves the list empty and both counters at zero. A stalled response
// holds in the output register; a new request is taken once it can drain.
`timescale 1ns / 1ps
`default_nettype none

module block_number_allocator (
	input  wire logic        clk,
	input  wire logic        arst_n,
	bna_req_if.sink          req,
	bna_rsp_if.source        rsp,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	bna_pkg::state_t  state_q, state_d;
	logic [31:0]      reserved_q, start_free_q, start_high_q;
	logic [31:0]      free_q, free_d, high_q, high_d;
	bna_pkg::tok_t    res_q, res_d;
	bna_pkg::tok_t    launch, chain_out;
	logic             out_valid_q;
	logic [31:0]      out_granted_q, out_free_q, out_high_q;
	bna_pkg::status_t out_status_q;
	logic             out_free, accept, load_out;
	logic [31:0]      nx_granted;
	bna_pkg::status_t nx_status;
	bna_pkg::action_t act;
	logic [31:0]      free_inc;

	assign out_free = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == bna_pkg::ST_IDLE) && out_free;
	assign accept   = req.valid && req.ready;
	assign act      = bna_pkg::action_t'(req.action);
	assign free_inc = (free_q == 32'hFFFF_FFFF) ? free_q : free_q + 32'd1;

	assign rsp.valid         = out_valid_q;
	assign rsp.granted_block = out_granted_q;
	assign rsp.status        = out_status_q;
	assign rsp.free_count    = out_free_q;
	assign rsp.highest_used  = out_high_q;

	bna_chain u_chain (
		.clk     (clk),
		.arst_n  (arst_n),
		.tok_in  (launch),
		.tok_out (chain_out)
	);

	always_comb begin
		state_d    = state_q;
		free_d     = free_q;
		high_d     = high_q;
		res_d      = res_q;
		launch     = '0;
		load_out   = 1'b0;
		nx_granted = 32'd0;
		nx_status  = bna_pkg::STATUS_OK;
		case (state_q)
			bna_pkg::ST_IDLE: begin
				if (accept) begin
					launch.op   = act;
					launch.data = (act == bna_pkg::ACT_RELEASE) ? req.block_number : 32'd0;
					case (act)
						bna_pkg::ACT_ALLOC: begin
							if (free_q == 32'd0) begin
								load_out  = 1'b1;
								nx_status = bna_pkg::STATUS_EMPTY;
							end else begin
								launch.active = 1'b1;
								state_d       = bna_pkg::ST_SCAN;
							end
						end
						bna_pkg::ACT_RELEASE: begin
							if (req.block_number <= reserved_q) begin
								load_out  = 1'b1;
								nx_status = bna_pkg::STATUS_RESERVED;
							end else if (req.block_number == high_q) begin
								load_out = 1'b1;
								high_d   = high_q - 32'd1;
								free_d   = free_inc;
							end else begin
								launch.active = 1'b1;
								state_d       = bna_pkg::ST_SCAN;
							end
						end
						bna_pkg::ACT_INIT: begin
							free_d        = start_free_q;
							high_d        = start_high_q;
							launch.active = 1'b1;
							state_d       = bna_pkg::ST_SCAN;
						end
						default: begin
							load_out = 1'b1;
						end
					endcase
				end
			end
			bna_pkg::ST_SCAN: begin
				if (chain_out.active) begin
					res_d   = chain_out;
					state_d = bna_pkg::ST_DONE;
				end
			end
			bna_pkg::ST_DONE: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = bna_pkg::ST_IDLE;
					case (res_q.op)
						bna_pkg::ACT_ALLOC: begin
							free_d = free_q - 32'd1;
							if (res_q.hit) begin
								nx_granted = res_q.data;
							end else begin
								high_d     = high_q + 32'd1;
								nx_granted = high_q + 32'd1;
							end
						end
						bna_pkg::ACT_RELEASE: begin
							if (res_q.hit) begin
								free_d = free_inc;
							end else begin
								nx_status = bna_pkg::STATUS_FULL;
							end
						end
						default: begin
						end
					endcase
				end
			end
			default: begin
				state_d = bna_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= bna_pkg::ST_IDLE;
			free_q       <= 32'd0;
			high_q       <= 32'd0;
			reserved_q   <= 32'd3;
			start_free_q <= 32'd0;
			start_high_q <= 32'd0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			free_q  <= free_d;
			high_q  <= high_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (bna_pkg::cfg_index_t'(cfg_index))
					bna_pkg::CFG_RESERVED_LAST:      reserved_q   <= cfg_data;
					bna_pkg::CFG_START_FREE_COUNT:   start_free_q <= cfg_data;
					bna_pkg::CFG_START_HIGHEST_USED: start_high_q <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
		if (load_out) begin
			out_granted_q <= nx_granted;
			out_status_q  <= nx_status;
			out_free_q    <= free_d;
			out_high_q    <= high_d;
		end
	end

	// token leaves the chain only while a scan is pending
	a_chain_exit: assert property (@(posedge clk) disable iff (!arst_n)
		chain_out.active |-> state_q == bna_pkg::ST_SCAN)
		else $error("scan token left chain outside scan state");

	// empty allocate answers in the next cycle
	a_empty_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		accept && act == bna_pkg::ACT_ALLOC && free_q == 32'd0
		|=> rsp.valid && rsp.status == bna_pkg::STATUS_EMPTY)
		else $error("empty allocate did not report no free blocks");

	// counters hold while the token walks the chain
	a_scan_stable: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bna_pkg::ST_SCAN && $past(state_q == bna_pkg::ST_SCAN)
		|-> $stable(free_q) && $stable(high_q))
		else $error("counters changed during scan");

	// only a successful allocate grants a block
	a_grant_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != bna_pkg::STATUS_OK |-> rsp.granted_block == 32'd0)
		else $error("block granted with an error status");

endmodule

`default_nettype wire

// ===== rtl/bna_cell.sv =====
// One free list slot with its scan stage.
// Depends on bna_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bna_cell (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire bna_pkg::tok_t tok_in,
	output bna_pkg::tok_t      tok_out,
	input  wire logic [31:0]   next_entry,
	output logic [31:0]        entry
);

	logic          valid_q;
	logic [31:0]   entry_q;
	bna_pkg::tok_t tok_s1;
	bna_pkg::tok_t tok_d;
	logic          wr_en;
	logic          wr_valid;
	logic [31:0]   wr_data;

	// a slot never written since reset or init reads as the terminator
	assign entry   = valid_q ? entry_q : 32'd0;
	assign tok_out = tok_s1;

	always_comb begin
		tok_d    = tok_in;
		wr_en    = 1'b0;
		wr_valid = 1'b0;
		wr_data  = 32'd0;
		if (tok_in.active) begin
			case (tok_in.op)
				bna_pkg::ACT_INIT: begin
					wr_en = 1'b1;
				end
				bna_pkg::ACT_ALLOC: begin
					if (!tok_in.stopped && entry != bna_pkg::FREE_MARKER) begin
						tok_d.stopped = 1'b1;
						if (entry != 32'd0) begin
							tok_d.hit  = 1'b1;
							tok_d.data = entry;
							wr_en      = 1'b1;
							wr_valid   = 1'b1;
							wr_data    = (next_entry == 32'd0) ? 32'd0 : bna_pkg::FREE_MARKER;
						end
					end
				end
				bna_pkg::ACT_RELEASE: begin
					if (tok_in.clear_next) begin
						wr_en            = 1'b1;
						tok_d.clear_next = 1'b0;
					end else if (!tok_in.stopped &&
						(entry == 32'd0 || entry == bna_pkg::FREE_MARKER)) begin
						tok_d.stopped    = 1'b1;
						tok_d.hit        = 1'b1;
						tok_d.clear_next = (entry == 32'd0);
						wr_en            = 1'b1;
						wr_valid         = 1'b1;
						wr_data          = tok_in.data;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tok_s1  <= '0;
		end else begin
			tok_s1 <= tok_d;
			if (wr_en) begin
				valid_q <= wr_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q <= wr_data;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/bna_chain.sv =====
// Row of free list cells; the scan token moves one cell per cycle.
// Depends on bna_pkg and bna_cell.
`timescale 1ns / 1ps
`default_nettype none

module bna_chain (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire bna_pkg::tok_t tok_in,
	output bna_pkg::tok_t      tok_out
);

	bna_pkg::tok_t tok   [bna_pkg::LIST_DEPTH+1];
	logic [31:0]   entry [bna_pkg::LIST_DEPTH];

	assign tok[0]  = tok_in;
	assign tok_out = tok[bna_pkg::LIST_DEPTH];

	for (genvar i = 0; i < bna_pkg::LIST_DEPTH; i++) begin : g_cell
		logic [31:0] next_entry;

		// past the last slot the list reads as terminated
		if (i == bna_pkg::LIST_DEPTH - 1) begin : g_last
			assign next_entry = 32'd0;
		end else begin : g_mid
			assign next_entry = entry[i+1];
		end

		bna_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.tok_in     (tok[i]),
			.tok_out    (tok[i+1]),
			.next_entry (next_entry),
			.entry      (entry[i])
		);
	end

endmodule

`default_nettype wire

// ===== sim/allocator_checker.sv =====
// Checker for the block number allocator: watches the request, response and
// register-write ports, predicts each response and compares it. Needs bna_pkg, bna_if.
`timescale 1ns / 1ps

module allocator_checker
	import bna_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	bna_req_if               req,
	bna_rsp_if               rsp,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	output int unsigned      mismatches,
	output int unsigned      outstanding
);

	typedef struct packed {
		logic [31:0] granted;
		status_t     status;
		logic [31:0] free_count;
		logic [31:0] highest;
	} outcome_t;

	logic [31:0] reserved_last;
	logic [31:0] start_free;
	logic [31:0] start_highest;
	logic [31:0] free_slots [LIST_DEPTH];
	logic [31:0] free_blocks;
	logic [31:0] highest_block;
	outcome_t    awaited_outcomes [$];

	// Applies one request to the shadow allocator state, returns the response it gives.
	function automatic outcome_t serve_request(action_t act, logic [31:0] blk);
		outcome_t    res;
		int unsigned idx;
		res.granted = '0;
		res.status = STATUS_OK;
		case (act)
			ACT_ALLOC: begin
				if (free_blocks == '0) begin
					res.status = STATUS_EMPTY;
				end else begin
					idx = 0;
					if (free_slots[0] != '0) begin
						while (idx < LIST_DEPTH && free_slots[idx] == FREE_MARKER)
							idx++;
						if (idx < LIST_DEPTH) begin
							if (free_slots[idx] != '0) begin
								res.granted = free_slots[idx];
								// last live entry collapses into the terminator
								if (idx == LIST_DEPTH - 1)
									free_slots[idx] = '0;
								else if (free_slots[idx + 1] == '0)
									free_slots[idx] = '0;
								else
									free_slots[idx] = FREE_MARKER;
							end
						end
					end
					// nothing usable in the list: grow past the highest mark (wraps)
					if (res.granted == '0) begin
						highest_block = highest_block + 32'd1;
						res.granted = highest_block;
					end
					free_blocks = free_blocks - 32'd1;
				end
			end
			ACT_RELEASE: begin
				if (blk <= reserved_last) begin
					res.status = STATUS_RESERVED;
				end else if (blk == highest_block) begin
					highest_block = highest_block - 32'd1;
				end else begin
					idx = 0;
					while (idx < LIST_DEPTH && free_slots[idx] != '0
							&& free_slots[idx] != FREE_MARKER)
						idx++;
					if (idx == LIST_DEPTH) begin
						res.status = STATUS_FULL;
					end else begin
						if (free_slots[idx] == '0 && idx + 1 < LIST_DEPTH)
							free_slots[idx + 1] = '0;
						free_slots[idx] = blk;
					end
				end
				if (res.status == STATUS_OK && free_blocks != '1)
					free_blocks = free_blocks + 32'd1;
			end
			ACT_INIT: begin
				for (idx = 0; idx < LIST_DEPTH; idx++)
					free_slots[idx] = '0;
				free_blocks = start_free;
				highest_block = start_highest;
			end
			default: ;
		endcase
		res.free_count = free_blocks;
		res.highest = highest_block;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t due;
		int       i;
		if (!arst_n) begin
			reserved_last = 32'd3;
			start_free = '0;
			start_highest = '0;
			for (i = 0; i < LIST_DEPTH; i++)
				free_slots[i] = '0;
			free_blocks = '0;
			highest_block = '0;
			awaited_outcomes.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index_t'(cfg_index))
					CFG_RESERVED_LAST:      reserved_last = cfg_data;
					CFG_START_FREE_COUNT:   start_free = cfg_data;
					CFG_START_HIGHEST_USED: start_highest = cfg_data;
					default: ;
				endcase
			end
			// responses are registered, so compare before queuing this edge's request
			if (rsp.valid && rsp.ready) begin
				if (awaited_outcomes.size() == 0) begin
					$display("%0t: unexpected response transaction, got %h %h %h %h",
						$time, rsp.granted_block, rsp.status, rsp.free_count,
						rsp.highest_used);
					mismatches++;
				end else begin
					due = awaited_outcomes.pop_front();
					if (rsp.granted_block !== due.granted) begin
						$display("%0t: granted_block expected %h, actual %h",
							$time, due.granted, rsp.granted_block);
						mismatches++;
					end
					if (rsp.status !== due.status) begin
						$display("%0t: status expected %h, actual %h",
							$time, due.status, rsp.status);
						mismatches++;
					end
					if (rsp.free_count !== due.free_count) begin
						$display("%0t: free_count expected %h, actual %h",
							$time, due.free_count, rsp.free_count);
						mismatches++;
					end
					if (rsp.highest_used !== due.highest) begin
						$display("%0t: highest_used expected %h, actual %h",
							$time, due.highest, rsp.highest_used);
						mismatches++;
					end
				end
			end
			if (req.valid && req.ready)
				awaited_outcomes.push_back(serve_request(action_t'(req.action),
					req.block_number));
			outstanding = awaited_outcomes.size();
		end
	end

endmodule

// ===== sim/testbench.sv =====
// Top of the allocator testbench: clock, reset, stimulus, register writes and verdict.
// Needs bna_pkg, bna_if, block_number_allocator and allocator_checker.
`timescale 1ns / 1ps

module testbench;
	import bna_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT = 4000;
	localparam int unsigned HOLDOFF_CYCLES = 400;
	localparam int unsigned DRAIN_CYCLES = 300;
	localparam int unsigned PHASE_ITEMS = 140;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;
	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned holdoff_requests;
	int unsigned holdoffs_served;
	logic [31:0] cur_reserved;
	logic [31:0] seen_highest = '0;

	bna_req_if req ();
	bna_rsp_if rsp ();

	block_number_allocator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	allocator_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.rsp         (rsp),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// the last reported mark steers some releases at the highest block
	always @(posedge clk) begin
		if (rsp.valid && rsp.ready)
			seen_highest <= rsp.highest_used;
	end

	// response side: random stalls, plus long hold-offs on request
	initial begin
		int unsigned held;
		held = 0;
		holdoffs_served = 0;
		rsp.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (holdoffs_served != holdoff_requests) begin
				rsp.ready <= 1'b0;
				held++;
				if (held == HOLDOFF_CYCLES) begin
					held = 0;
					holdoffs_served++;
				end
			end else begin
				rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("testbench: done, errors");
		$finish;
	end

	// Called at a falling edge; returns at the falling edge after the transaction,
	// leaving valid high so back-to-back requests need no second assignment.
	task automatic offer(input action_t act, input logic [31:0] blk);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid <= 1'b1;
		req.action <= act;
		req.block_number <= blk;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		do
			@(negedge clk);
		while (outstanding != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_register(input cfg_index_t idx, input logic [31:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic start_phase(input int unsigned idle, input int unsigned stall,
			input logic [31:0] reserved, input logic [31:0] free_cnt,
			input logic [31:0] top_mark);
		drain();
		send_idle_pct = idle;
		recv_stall_pct = stall;
		cur_reserved = reserved;
		write_register(CFG_RESERVED_LAST, reserved);
		write_register(CFG_START_FREE_COUNT, free_cnt);
		write_register(CFG_START_HIGHEST_USED, top_mark);
		offer(ACT_INIT, $urandom());
	endtask

	task automatic random_request();
		int unsigned pick;
		logic [31:0] blk;
		pick = $urandom_range(99);
		blk = $urandom();
		if (pick < 42) begin
			offer(ACT_ALLOC, blk);
		end else if (pick < 92) begin
			pick = $urandom_range(99);
			if (pick < 15)
				blk = seen_highest;
			else if (pick < 75)
				blk = cur_reserved + $urandom_range(1, 300);
			else if (pick < 85)
				blk = $urandom_range(cur_reserved);
			offer(ACT_RELEASE, blk);
		end else if (pick < 95) begin
			offer(ACT_INIT, blk);
		end else begin
			offer(ACT_NOP, blk);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.action = ACT_NOP;
		req.block_number = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_RESERVED_LAST;
		cfg_data = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		holdoff_requests = 0;
		cur_reserved = 32'd3;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: allocate before any init, then walk the list by hand
		offer(ACT_ALLOC, 32'hFFFF_FFFF);
		drain();
		write_register(CFG_RESERVED_LAST, 32'd3);
		write_register(CFG_START_FREE_COUNT, 32'd5);
		write_register(CFG_START_HIGHEST_USED, 32'd10);
		write_register(CFG_UNUSED, $urandom());
		offer(ACT_NOP, 32'hFFFF_FFFF);
		offer(ACT_INIT, 32'd0);
		offer(ACT_ALLOC, 32'd0);
		offer(ACT_RELEASE, 32'd3);
		offer(ACT_RELEASE, 32'd11);
		offer(ACT_RELEASE, 32'd7);
		offer(ACT_RELEASE, 32'd8);
		offer(ACT_RELEASE, 32'd9);
		offer(ACT_ALLOC, 32'd0);
		offer(ACT_ALLOC, 32'd0);
		offer(ACT_RELEASE, 32'd5);
		offer(ACT_ALLOC, 32'd0);
		offer(ACT_ALLOC, 32'd0);
		offer(ACT_ALLOC, 32'd0);
		offer(ACT_RELEASE, 32'hFFFF_FFFF);
		// saturating free count and a wrapping mark
		drain();
		cur_reserved = '0;
		write_register(CFG_RESERVED_LAST, 32'd0);
		write_register(CFG_START_FREE_COUNT, 32'hFFFF_FFFF);
		write_register(CFG_START_HIGHEST_USED, 32'hFFFF_FFFF);
		offer(ACT_INIT, 32'hFFFF_FFFF);
		offer(ACT_RELEASE, 32'd1);
		offer(ACT_ALLOC, 32'd0);
		offer(ACT_ALLOC, 32'd0);
		offer(ACT_RELEASE, 32'd0);
		// every release reserved
		drain();
		write_register(CFG_RESERVED_LAST, 32'hFFFF_FFFF);
		write_register(CFG_START_FREE_COUNT, 32'd0);
		write_register(CFG_START_HIGHEST_USED, 32'd0);
		offer(ACT_RELEASE, 32'hFFFF_FFFF);
		offer(ACT_INIT, 32'd0);
		offer(ACT_ALLOC, 32'd0);

		start_phase(0, 0, 32'd0, $urandom_range(20), $urandom_range(1, 100));
		repeat (PHASE_ITEMS) random_request();

		start_phase(79, 0, $urandom_range(1, 50), $urandom_range(100, 1000),
			$urandom_range(60, 150));
		repeat (PHASE_ITEMS) random_request();

		start_phase(0, 79, 32'd3, 32'd0, 32'd150);
		holdoff_requests++;
		repeat (PHASE_ITEMS) random_request();

		start_phase(24, 24, $urandom_range(20), 32'hFFFF_FFFE, 32'hFFFF_FFF0);
		repeat (PHASE_ITEMS) random_request();

		// fill the list past its depth, then mix allocations back in
		start_phase(24, 24, 32'd3, $urandom_range(10), 32'd6000);
		holdoff_requests++;
		repeat (265) offer(ACT_RELEASE, $urandom_range(4, 5999));
		repeat (35) random_request();

		drain();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
